[rtl/core/cqd_pkg.sv]
// Shared types, codes and sizes for the circular queue with dump.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cqd_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CAP_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // Action codes
    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_DISP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Register index (word address bit of paddr)
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] item;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic               last;
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic       enq;
        logic       deq;
        logic       walk_start;
        logic       walk_step;
        logic       emit;
        logic [1:0] emit_status;
        logic       emit_last;
        logic       emit_mem;
        logic       emit_echo;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic head_is_tail;
        logic walk_fin;
    } stat_t;

endpackage

[rtl/core/cqd_ctrl.sv]
// Controller for the circular queue: decodes the action and sequences the display walk.
// Depends on cqd_pkg.
`timescale 1ns / 1ps

module cqd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    action,
    input  cqd_pkg::stat_t stat,
    output cqd_pkg::cmd_t  cmd,
    output logic          busy
);
    import cqd_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_ENQ:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.enq         = 1'b1;
                                cmd.emit_status = ST_OK;
                                cmd.emit_echo   = 1'b1;
                            end
                        end
                        ACT_DEQ:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.deq         = 1'b1;
                                cmd.emit_status = ST_OK;
                                cmd.emit_mem    = 1'b1;
                            end
                        end
                        ACT_DISP:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.emit_status = ST_EMPTY;
                                cmd.emit_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.walk_start  = 1'b1;
                                cmd.emit_status = ST_OK;
                                cmd.emit_mem    = 1'b1;
                                cmd.emit_last   = stat.head_is_tail;
                                if (!stat.head_is_tail)
                                begin
                                    state_next = S_WALK;
                                end
                            end
                        end
                        default:
                        begin
                            // unused code: drop the beat
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.walk_step   = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OK;
                cmd.emit_mem    = 1'b1;
                cmd.emit_last   = stat.walk_fin;
                if (stat.walk_fin)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_WALK);

endmodule

[rtl/core/cqd_dp.sv]
// Datapath for the circular queue: entry store, indices, capacity register, result registers.
// Depends on cqd_pkg.
`timescale 1ns / 1ps

module cqd_dp
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cqd_pkg::cmd_t             cmd,
    input  logic signed [31:0]        item,
    input  logic                      cfg_wr,
    input  logic [cqd_pkg::CAP_W-1:0] cfg_data,
    output cqd_pkg::stat_t            stat,
    output logic [cqd_pkg::CAP_W-1:0] capacity,
    output logic                      done,
    output cqd_pkg::res_t             res
);
    import cqd_pkg::*;

    logic [31:0]      mem [DEPTH];
    logic [31:0]      rd_data_reg;

    logic [CAP_W-1:0] cap_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic             empty_reg;
    logic             empty_next;
    logic [IDX_W-1:0] walk_idx_reg;
    logic [IDX_W-1:0] walk_idx_next;
    logic [IDX_W-1:0] walk_cnt_reg;
    logic [IDX_W-1:0] walk_cnt_next;

    logic             done_reg;
    logic [1:0]       status_reg;
    logic             last_reg;
    logic             mem_sel_reg;
    logic [31:0]      echo_reg;

    logic [IDX_W-1:0] cap_m1;
    logic [IDX_W-1:0] head_adv;
    logic [IDX_W-1:0] tail_adv;
    logic [IDX_W-1:0] walk_adv;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
                                             input logic [IDX_W-1:0] lim);
        logic [IDX_W-1:0] r;
        if (i >= lim)
        begin
            r = '0;
        end
        else
        begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    // Clamp capacity to 1..DEPTH and take the wrap point
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_m1 = '0;
        end
        else if (cap_reg > CAP_W'(DEPTH))
        begin
            cap_m1 = IDX_W'(DEPTH - 1);
        end
        else
        begin
            cap_m1 = IDX_W'(cap_reg - 1'b1);
        end
    end

    assign head_adv = adv(head_reg, cap_m1);
    assign tail_adv = adv(tail_reg, cap_m1);
    assign walk_adv = adv(walk_idx_reg, cap_m1);

    assign stat.empty        = empty_reg;
    assign stat.full         = !empty_reg && (tail_adv == head_reg);
    assign stat.head_is_tail = (head_reg == tail_reg);
    assign stat.walk_fin     = (walk_idx_reg == tail_reg) ||
                               (walk_cnt_reg == IDX_W'(DEPTH - 1));

    assign wr_addr = empty_reg ? '0 : tail_adv;
    assign rd_addr = cmd.walk_step ? walk_idx_reg : head_reg;
    assign rd_en   = cmd.deq || cmd.walk_start || cmd.walk_step;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        walk_idx_next = walk_idx_reg;
        walk_cnt_next = walk_cnt_reg;
        if (cfg_wr)
        begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
        end
        else if (cmd.enq)
        begin
            if (empty_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
            end
            else
            begin
                tail_next = tail_adv;
            end
        end
        else if (cmd.deq)
        begin
            if (head_reg == tail_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
            end
            else
            begin
                head_next = head_adv;
            end
        end
        if (cmd.walk_start)
        begin
            walk_idx_next = head_adv;
            walk_cnt_next = IDX_W'(1);
        end
        else if (cmd.walk_step)
        begin
            walk_idx_next = walk_adv;
            walk_cnt_next = walk_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            walk_idx_reg <= '0;
            walk_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                cap_reg <= cfg_data;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            empty_reg    <= empty_next;
            walk_idx_reg <= walk_idx_next;
            walk_cnt_reg <= walk_cnt_next;
            done_reg     <= cmd.emit;
        end
    end

    // Entry store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            mem[wr_addr] <= item;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            last_reg    <= cmd.emit_last;
            mem_sel_reg <= cmd.emit_mem;
            echo_reg    <= cmd.emit_echo ? item : '0;
        end
    end

    assign capacity   = cap_reg;
    assign done       = done_reg;
    assign res.status = status_reg;
    assign res.value  = mem_sel_reg ? rd_data_reg : echo_reg;
    assign res.last   = last_reg;

endmodule

[rtl/core/circular_queue_with_dump.sv]
// Top level of the circular queue with dump: APB register decode, controller and datapath.
// Depends on cqd_pkg, cqd_ctrl and cqd_dp.
//
//  channel   direction  handshake                     payload
//  request   in         start & !busy                 req   (action, item)
//  result    out        done, one cycle, no stall     res   (status, value, last)
//  config    in         psel & penable & pwrite       pwdata[4:0] -> capacity (paddr 0)
//
// Enqueue and dequeue take one cycle: the result strobes in the cycle after the beat and
// the next request may be taken in that same cycle.
// Display of n entries gives n results on consecutive cycles, one read of the entry
// store each; for n above one, busy is high from the cycle after the beat until the last read is issued.
// Reset leaves the queue empty with capacity 16; a capacity write empties the queue.
// The receiver cannot stall: each result is valid for its single done cycle.
`timescale 1ns / 1ps

module circular_queue_with_dump
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cqd_pkg::req_t               req,
    output logic                        done,
    output cqd_pkg::res_t               res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cqd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cqd_pkg::DATA_W-1:0]  pwdata,
    output logic [cqd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import cqd_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic             cfg_wr;
    logic [CAP_W-1:0] capacity;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

    cqd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (req.action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    cqd_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (req.item),
        .cfg_wr   (cfg_wr),
        .cfg_data (pwdata[CAP_W-1:0]),
        .stat     (stat),
        .capacity (capacity),
        .done     (done),
        .res      (res)
    );

endmodule

[rtl/core/cqd_chk.sv]
// Port-level checks for the circular queue with dump, bound to the top level.
// Depends on cqd_pkg and circular_queue_with_dump.
`timescale 1ns / 1ps

module cqd_chk
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input cqd_pkg::req_t  req,
    input logic           done,
    input cqd_pkg::res_t  res
);
    import cqd_pkg::*;

    // Enqueue and dequeue answer with a final result next cycle
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.action == ACT_ENQ || req.action == ACT_DEQ)
        |=> done && res.last)
        else $error("enqueue/dequeue did not give one final result");

    // An unused action code gives no result
    a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.action != ACT_ENQ && req.action != ACT_DEQ &&
        req.action != ACT_DISP
        |=> !done)
        else $error("result after unused action");

    // Display results run back to back until the last one
    a_walk_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        done && !res.last |=> done)
        else $error("gap inside a display walk");

    // Error statuses always end the item
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && res.status != ST_OK |-> res.last)
        else $error("error status without last");

endmodule

bind circular_queue_with_dump cqd_chk u_cqd_chk
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
);
